// File: rtl/core/bmba_pkg.sv
// bmba_pkg: item types, request and status codes, fixed field widths
// for the bitmap block allocator. No dependencies.
`default_nettype none
package bmba_pkg;

  localparam int BLK_W = 16;
  localparam int CNT_W = 17;
  localparam int CFG_W = 17;

  localparam logic [1:0] REQ_FORMAT   = 2'd0;
  localparam logic [1:0] REQ_ALLOCATE = 2'd1;
  localparam logic [1:0] REQ_FREE     = 2'd2;
  localparam logic [1:0] REQ_QUERY    = 2'd3;

  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_NO_FREE      = 3'd1;
  localparam logic [2:0] ST_ALREADY_USED = 3'd2;
  localparam logic [2:0] ST_ALREADY_FREE = 3'd3;
  localparam logic [2:0] ST_OUT_OF_RANGE = 3'd4;

  localparam logic CFG_TOTAL = 1'b0;
  localparam logic CFG_FIRST = 1'b1;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [BLK_W-1:0] block_number;
  } req_t;

  typedef struct packed {
    logic [BLK_W-1:0] result_block;
    logic [2:0]       status;
    logic             bit_value;
    logic [CNT_W-1:0] free_count;
  } rsp_t;

endpackage
`default_nettype wire

// File: rtl/core/bmba_ram.sv
// bmba_ram: generic simple dual-port RAM, one write and one registered read
// per cycle. No dependencies.
`default_nettype none
module bmba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/core/bmba_div.sv
// bmba_div: splits a block number by a constant divisor into map word index and
// bit offset with a reciprocal multiply; start passes through v1 and v2 to done. No dependencies.
`default_nettype none
module bmba_div #(
  parameter int DW      = 16,
  parameter int DIVISOR = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [DW-1:0]                dividend,
  output logic                              done,
  output logic      [DW-1:0]                quotient,
  output logic      [$clog2(DIVISOR)-1:0]   remainder
);

  localparam int KW = $clog2(DIVISOR);
  localparam int SH = DW + KW;
  localparam int MW = DW + 2;
  localparam int PW = (SH + DW > DW + MW) ? SH + DW : DW + MW;
  localparam logic [MW-1:0] RECIP =
    MW'(((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

  logic          v1;
  logic          v2;
  logic [DW-1:0] held;
  logic [PW-1:0] prod;
  logic [DW-1:0] q;
  logic [KW-1:0] r;
  logic [KW-1:0] qd;

  assign qd        = KW'(q * DIVISOR);
  assign quotient  = q;
  assign remainder = r;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start;
      v2   <= v1;
      done <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      held <= dividend;
      prod <= PW'(dividend) * PW'(RECIP);
    end
    if (v1) begin
      q <= prod[SH +: DW];
    end
    if (v2) begin
      r <= held[KW-1:0] - qd;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/bitmap_block_allocator_unit.sv
// Per item: format writes the map word by word (one map word written per cycle), then responds;
// allocate scans the map (one map word read per cycle, ends at the first word with a clear bit or
// at the total); free and query split the block number in bmba_div, then read and check the map
// word, and a free writes it back; out of range and no-free go straight to the response state.
// One item at a time: the next item is taken in the cycle after the result loads the output
// register. After reset a clearing pass zeroes the map with req_stall high; config writes still land.
`default_nettype none
module bitmap_block_allocator_unit
  import bmba_pkg::*;
#(
  parameter int MAX_BLOCKS    = 65536,
  parameter int MAP_WORD_BITS = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_valid,
  output logic                  req_stall,
  input  wire req_t             req,
  output logic                  rsp_valid,
  input  wire logic             rsp_stall,
  output rsp_t                  rsp,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  localparam int W     = MAP_WORD_BITS;
  localparam int WORDS = (MAX_BLOCKS + W - 1) / W;
  localparam int AW    = WORDS > 1 ? $clog2(WORDS) : 1;
  localparam int KW    = $clog2(W);
  localparam int BW    = $clog2(MAX_BLOCKS + 2 * W) + 1;
  localparam int XW    = BW > CFG_W + 1 ? BW : CFG_W + 1;
  localparam logic [31:0] MAX32 = 32'(MAX_BLOCKS);
  localparam logic [W-1:0] ONES = {W{1'b1}};

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FMT  = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_CHK  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]       state;
  logic [1:0]       op;
  logic [BLK_W-1:0] blk;
  logic [CFG_W-1:0] total_blocks;
  logic [CFG_W-1:0] first_data_block;
  logic [CNT_W-1:0] free_blocks;
  logic [CFG_W-1:0] fmt_used;
  logic             fmt_report;
  logic [AW-1:0]    fa;
  logic [XW-1:0]    fb;
  logic [AW-1:0]    ra;
  logic [XW-1:0]    rb;
  logic             ra_done;
  logic [AW-1:0]    ca;
  logic [XW-1:0]    cb;
  logic             cv;
  logic             cl;
  logic [AW-1:0]    qaddr;
  logic [KW-1:0]    qrem;
  rsp_t             pend;

  logic [CFG_W-1:0] eff_total;
  logic [XW-1:0]    tot_x;
  logic [CFG_W-1:0] used_now;
  logic             accept;
  logic             rsp_load;
  logic [XW-1:0]    used_x;
  logic [XW-1:0]    fmt_diff;
  logic [W-1:0]     fmt_word;
  logic [W-1:0]     word;
  logic [KW-1:0]    zk;
  logic             word_full;
  logic [XW-1:0]    pos;
  logic             scan_hit;
  logic             scan_fail;
  logic             bit_sel;
  logic [W-1:0]     bmask;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [W-1:0]     ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic             div_start;
  logic             div_done;
  logic [BLK_W-1:0] div_q;
  logic [KW-1:0]    div_r;
  logic             in_range;

  assign eff_total = (32'(total_blocks) > MAX32) ? CFG_W'(MAX_BLOCKS) : total_blocks;
  assign tot_x     = XW'(eff_total);
  assign used_now  = (first_data_block > eff_total) ? eff_total : first_data_block;
  assign accept    = req_valid && !req_stall;
  assign req_stall = (state != S_IDLE);
  assign rsp_load  = (state == S_DONE) && (!rsp_valid || !rsp_stall);
  assign in_range  = XW'(req.block_number) < tot_x;
  assign div_start = accept && (req.req_type == REQ_FREE || req.req_type == REQ_QUERY)
                     && in_range;

  assign used_x   = XW'(fmt_used);
  assign fmt_diff = used_x - fb;
  assign fmt_word = (fb >= used_x) ? '0 :
                    (fmt_diff >= XW'(W)) ? ONES : ~(ONES << fmt_diff[KW-1:0]);

  always_comb begin
    zk = '0;
    for (int j = W - 1; j >= 0; j--) begin
      if (!word[j]) begin
        zk = KW'(j);
      end
    end
  end

  assign word_full = &word;
  assign pos       = cb + XW'(zk);
  assign scan_hit  = cv && (cb < tot_x) && !word_full && (pos < tot_x);
  assign scan_fail = cv && ((cb >= tot_x) || (!word_full && pos >= tot_x) || (word_full && cl));
  assign bit_sel   = word[qrem];
  assign bmask     = W'(1) << qrem;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = fa;
    ram_wdata = fmt_word;
    if (state == S_FMT) begin
      ram_we = 1'b1;
    end else if (state == S_SCAN && scan_hit) begin
      ram_we    = 1'b1;
      ram_waddr = ca;
      ram_wdata = word | (W'(1) << zk);
    end else if (state == S_CHK && op == REQ_FREE && bit_sel) begin
      ram_we    = 1'b1;
      ram_waddr = qaddr;
      ram_wdata = word & ~bmask;
    end
    ram_raddr = (state == S_SCAN) ? ra : qaddr;
  end

  bmba_ram #(
    .WIDTH (W),
    .DEPTH (WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (word)
  );

  bmba_div #(
    .DW      (BLK_W),
    .DIVISOR (W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (req.block_number),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      total_blocks     <= CFG_W'(65536);
      first_data_block <= CFG_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TOTAL: total_blocks     <= cfg_data;
        CFG_FIRST: first_data_block <= cfg_data;
        default:   total_blocks     <= total_blocks;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_FMT;
      fa          <= '0;
      fb          <= '0;
      fmt_used    <= '0;
      fmt_report  <= 1'b0;
      free_blocks <= '0;
      ra_done     <= 1'b0;
      cv          <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op  <= req.req_type;
            blk <= req.block_number;
            unique case (req.req_type)
              REQ_FORMAT: begin
                fa          <= '0;
                fb          <= '0;
                fmt_used    <= used_now;
                fmt_report  <= 1'b1;
                free_blocks <= eff_total - used_now;
                state       <= S_FMT;
              end
              REQ_ALLOCATE: begin
                if (free_blocks == '0) begin
                  pend  <= '{result_block: '0, status: ST_NO_FREE, bit_value: 1'b0,
                             free_count: free_blocks};
                  state <= S_DONE;
                end else begin
                  ra      <= '0;
                  rb      <= '0;
                  ra_done <= 1'b0;
                  cv      <= 1'b0;
                  state   <= S_SCAN;
                end
              end
              default: begin
                if (!in_range) begin
                  pend  <= '{result_block: req.block_number, status: ST_OUT_OF_RANGE,
                             bit_value: 1'b0, free_count: free_blocks};
                  state <= S_DONE;
                end else begin
                  state <= S_DIV;
                end
              end
            endcase
          end
        end
        S_FMT: begin
          fa <= fa + AW'(1);
          fb <= fb + XW'(W);
          if (fa == AW'(WORDS - 1)) begin
            pend  <= '{result_block: '0, status: ST_OK, bit_value: 1'b0,
                       free_count: free_blocks};
            state <= fmt_report ? S_DONE : S_IDLE;
          end
        end
        S_SCAN: begin
          cv <= !ra_done;
          ca <= ra;
          cb <= rb;
          cl <= (ra == AW'(WORDS - 1));
          if (!ra_done) begin
            if (ra == AW'(WORDS - 1)) begin
              ra_done <= 1'b1;
            end else begin
              ra <= ra + AW'(1);
            end
            rb <= rb + XW'(W);
          end
          if (scan_hit) begin
            free_blocks <= free_blocks - CNT_W'(1);
            pend  <= '{result_block: pos[BLK_W-1:0], status: ST_OK, bit_value: 1'b0,
                       free_count: free_blocks - CNT_W'(1)};
            state <= S_DONE;
          end else if (scan_fail) begin
            pend  <= '{result_block: '0, status: ST_NO_FREE, bit_value: 1'b0,
                       free_count: free_blocks};
            state <= S_DONE;
          end
        end
        S_DIV: begin
          if (div_done) begin
            qaddr <= AW'(div_q);
            qrem  <= div_r;
            state <= S_RD;
          end
        end
        S_RD: begin
          state <= S_CHK;
        end
        S_CHK: begin
          if (op == REQ_QUERY) begin
            pend <= '{result_block: blk, status: ST_OK, bit_value: bit_sel,
                      free_count: free_blocks};
          end else if (!bit_sel) begin
            pend <= '{result_block: blk, status: ST_ALREADY_FREE, bit_value: 1'b0,
                      free_count: free_blocks};
          end else begin
            free_blocks <= free_blocks + CNT_W'(1);
            pend <= '{result_block: blk, status: ST_OK, bit_value: 1'b0,
                      free_count: free_blocks + CNT_W'(1)};
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (rsp_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp <= pend;
    end
  end

  a_alloc_dec: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && scan_hit) |=> free_blocks == $past(free_blocks) - CNT_W'(1))
    else $error("allocate hit did not decrement free count");

  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && (state == S_IDLE || state == S_DONE || state == S_DIV)))
    else $error("map written outside a working state");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside split state");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    rsp_load |-> (!rsp_valid || !rsp_stall))
    else $error("waiting result overwritten");

endmodule
`default_nettype wire
